/* design/rru_pkg.sv */
`timescale 1ns / 1ps
package rru_pkg;
    localparam int MODE_W = 2;
    localparam int IDX_W = 6;
    localparam int VAL_W = 16;
    localparam int ACC_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_MASK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIAS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FEAT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0] neuron_index;
        logic [IDX_W-1:0] feature_index;
        logic signed [VAL_W-1:0] value;
        logic last;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] neuron_number;
        logic signed [VAL_W-1:0] state_value;
        logic final_res;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_item_t;

    // Control from the sequencer to every cell in the chain.
    typedef struct packed {
        logic acc_en;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic logic [12:0] sig_tab(input logic [4:0] k);
        logic [12:0] r;
        case (k)
            5'd0: r = 13'd2048;
            5'd1: r = 13'd2550;
            5'd2: r = 13'd2994;
            5'd3: r = 13'd3349;
            5'd4: r = 13'd3608;
            5'd5: r = 13'd3785;
            5'd6: r = 13'd3902;
            5'd7: r = 13'd3976;
            5'd8: r = 13'd4022;
            5'd9: r = 13'd4051;
            5'd10: r = 13'd4069;
            5'd11: r = 13'd4079;
            5'd12: r = 13'd4086;
            5'd13: r = 13'd4090;
            5'd14: r = 13'd4092;
            5'd15: r = 13'd4094;
            default: r = 13'd4095;
        endcase
        return r;
    endfunction
endpackage

/* design/rru_stream_if.sv */
`timescale 1ns / 1ps
interface rru_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/rru_cell.sv */
`timescale 1ns / 1ps
module rru_cell (
    input  logic clk,
    input  logic rst_n,
    input  rru_pkg::cell_ctrl_t ctrl,
    input  logic signed [15:0] feat,
    input  logic signed [15:0] mask_w,
    input  logic signed [31:0] acc_in,
    input  logic signed [15:0] prev_in,
    output logic signed [31:0] acc_out,
    output logic signed [15:0] prev_out
);
    import rru_pkg::*;

    logic signed [31:0] acc_reg;
    logic signed [15:0] prev_reg;
    logic signed [31:0] acc_next;
    logic signed [32:0] sum;

    assign sum = 33'(acc_in) + 33'(mask_w * feat);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.shift)
        begin
            if (!ctrl.acc_en)
            begin
                acc_next = acc_in;
            end
            else if (sum > 33'sd2147483647)
            begin
                acc_next = 32'sh7fffffff;
            end
            else if (sum < -33'sd2147483648)
            begin
                acc_next = 32'sh80000000;
            end
            else
            begin
                acc_next = sum[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (ctrl.shift)
            begin
                prev_reg <= prev_in;
            end
        end
    end

    assign acc_out = acc_reg;
    assign prev_out = prev_reg;
endmodule

/* design/rru_neuron_eval.sv */
`timescale 1ns / 1ps
module rru_neuron_eval (
    input  logic clk,
    input  logic signed [31:0] acc,
    input  logic signed [15:0] bias,
    input  logic signed [15:0] prev,
    input  logic signed [15:0] input_gain,
    input  logic signed [15:0] feedback_gain,
    input  logic [14:0] slope,
    input  logic signed [15:0] offset,
    output logic signed [15:0] state
);
    import rru_pkg::*;

    logic signed [32:0] pre_wide;
    logic signed [31:0] pre_reg;
    logic signed [15:0] prev1_reg;
    logic signed [47:0] gp_reg;
    logic signed [31:0] fp_reg;
    logic signed [48:0] s;
    logic signed [24:0] t_reg;
    logic signed [40:0] tz;
    logic signed [28:0] z;
    logic signed [28:0] z_reg;
    logic [28:0] a;
    logic [12:0] y0;
    logic [12:0] y1;
    logic signed [13:0] dt;
    logic signed [25:0] interp;
    logic signed [13:0] y;
    logic signed [13:0] ys;
    logic signed [17:0] diff;

    assign pre_wide = 33'(acc) + 33'(bias) * 33'sd4096;

    always_ff @(posedge clk)
    begin
        if (pre_wide > 33'sd2147483647)
        begin
            pre_reg <= 32'sh7fffffff;
        end
        else if (pre_wide < -33'sd2147483648)
        begin
            pre_reg <= 32'sh80000000;
        end
        else
        begin
            pre_reg <= pre_wide[31:0];
        end
        prev1_reg <= prev;
        gp_reg <= 48'(pre_reg) * 48'(input_gain);
        fp_reg <= 32'(prev1_reg) * 32'(feedback_gain);
        t_reg <= s[48:24];
        z_reg <= z;
    end

    assign s = 49'(gp_reg) + (49'(fp_reg) <<< 12) + 49'sd8388608;
    assign tz = 41'(t_reg) * 41'(signed'({1'b0, slope})) + 41'sd2048;
    assign z = tz[40:12];
    assign a = z_reg[28] ? 29'(-z_reg) : 29'(z_reg);
    assign y0 = sig_tab({1'b0, a[14:11]});
    assign y1 = sig_tab(5'(a[14:11]) + 5'd1);
    assign dt = signed'({1'b0, y1}) - signed'({1'b0, y0});
    assign interp = 26'(dt) * 26'(signed'({1'b0, a[10:0]})) + 26'sd1024;

    always_comb
    begin
        if (a >= 29'd32768)
        begin
            y = 14'sd4095;
        end
        else
        begin
            // Rounding shift: half is added before the arithmetic shift; the product is never negative here.
            y = signed'({1'b0, y0}) + 14'(interp >>> 11);
        end
        ys = z_reg[28] ? 14'sd4096 - y : y;
        diff = 18'(ys) - 18'(offset);
        if (diff > 18'sd32767)
        begin
            state = 16'sh7fff;
        end
        else if (diff < -18'sd32768)
        begin
            state = 16'sh8000;
        end
        else
        begin
            state = diff[15:0];
        end
    end
endmodule

/* design/ring_reservoir_update.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_ch     in   mode, neuron_index, feature_index, value, last
// out_ch    out  neuron_number, state_value, final_res
// cfg_ch    in   index, data (input_gain, feedback_gain, slope, offset)
// A feature sample holds the input while the mask memory is read one neuron a cycle
// and the accumulator chain rotates once. An update on last then evaluates one neuron
// at a time through the eval pipeline, and a rotation moves the new states into place.
// Reset clears accumulators, states and control registers and loads the config defaults;
// stores stay unwritten.
// The output register holds under stall, and a stalled output holds back the next
// evaluation step.
module ring_reservoir_update #(
    parameter int NEURONS = 64,
    parameter int FEATURES = 64,
    parameter int RING_SHIFT = 1
) (
    input logic clk,
    input logic rst_n,
    rru_stream_if.sink in_ch,
    rru_stream_if.source out_ch,
    rru_stream_if.sink cfg_ch
);
    import rru_pkg::*;

    localparam int NW = $clog2(NEURONS);
    localparam int MA_W = NW + IDX_W;
    localparam int SH = RING_SHIFT % NEURONS;
    localparam int LAT = 4;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_ROT = 2'd3;

    in_item_t in_item;
    cfg_item_t cfg_item;
    assign in_item = in_ch.payload;
    assign cfg_item = cfg_ch.payload;

    logic signed [15:0] input_gain_reg, feedback_gain_reg, offset_reg;
    logic [14:0] slope_reg;
    logic [1:0] st_reg, st_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [6:0] issued_reg, issued_next;
    logic [6:0] done_reg, done_next;
    logic signed [15:0] feat_reg;
    logic [IDX_W-1:0] fidx_reg;
    logic feat_ok_reg;
    logic last_reg;

    logic signed [15:0] mask_mem [NEURONS*64];
    logic signed [15:0] bias_mem [NEURONS];
    logic signed [15:0] mask_rd_reg;
    logic signed [15:0] bias_rd_reg;
    logic [NW-1:0] rd_n;
    logic [MA_W-1:0] wr_addr;
    logic [MA_W-1:0] rd_addr;
    logic load_n_ok, load_f_ok;

    logic signed [31:0] acc_q [NEURONS];
    logic signed [15:0] prev_q [NEURONS];
    logic signed [15:0] mask_w [NEURONS];
    logic signed [15:0] prev_fb;
    cell_ctrl_t cell_ctrl;

    logic in_acc, cfg_acc, out_take, step;
    logic [LAT:0] vpipe_reg;
    logic [NW-1:0] npipe_reg [LAT+1];
    logic signed [15:0] state_eval;
    logic signed [31:0] acc_sel_reg;
    logic signed [15:0] prev_sel_reg;
    logic out_v_reg;
    out_item_t out_reg;
    logic out_free;

    assign in_acc = in_ch.valid & in_ch.ready;
    assign cfg_acc = cfg_ch.valid & cfg_ch.ready;
    assign in_ch.ready = (st_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_take = out_ch.valid & out_ch.ready;
    assign out_ch.valid = out_v_reg;
    assign out_ch.payload = out_reg;
    assign out_free = !out_v_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_gain_reg <= 16'sd4096;
            feedback_gain_reg <= 16'sd4096;
            slope_reg <= 15'd4096;
            offset_reg <= 16'sd2048;
        end
        else if (cfg_acc)
        begin
            case (cfg_item.index)
                REG_INPUT_GAIN: input_gain_reg <= cfg_item.data;
                REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_item.data;
                REG_SLOPE: slope_reg <= cfg_item.data[14:0];
                REG_OFFSET: offset_reg <= cfg_item.data;
                default: ;
            endcase
        end
    end

    // Evaluation stepping: only issue when the whole pipe plus output can drain.
    assign step = (st_reg == ST_EVAL) && (issued_reg < 7'(NEURONS))
        && (issued_reg == done_reg) && out_free;

    assign load_n_ok = {1'b0, in_item.neuron_index} < 7'(NEURONS);
    assign load_f_ok = {1'b0, in_item.feature_index} < 7'(FEATURES);
    assign wr_addr = {in_item.neuron_index[NW-1:0], in_item.feature_index};
    assign rd_addr = {rd_n, fidx_reg};

    always_ff @(posedge clk)
    begin
        if (in_acc && in_item.mode == MODE_MASK && load_n_ok && load_f_ok)
        begin
            mask_mem[wr_addr] <= in_item.value;
        end
        if (in_acc && in_item.mode == MODE_BIAS && load_n_ok)
        begin
            bias_mem[in_item.neuron_index[NW-1:0]] <= in_item.value;
        end
        mask_rd_reg <= mask_mem[rd_addr];
        bias_rd_reg <= bias_mem[rd_n];
    end

    // The chain rotates toward cell 0; cell 0 holds neuron cnt.
    assign rd_n = NW'((st_reg == ST_EVAL) ? issued_reg : cnt_reg);

    // During evaluation the fresh state enters the chain as its neuron leaves cell 0.
    assign prev_fb = (st_reg == ST_EVAL) ? state_eval : prev_q[0];

    genvar g;
    generate
        for (g = 0; g < NEURONS; g++)
        begin : gen_cell
            assign mask_w[g] = (g == NEURONS - 1) ? mask_rd_reg : 16'sd0;
            rru_cell u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .ctrl(cell_ctrl),
                .feat(feat_reg),
                .mask_w(mask_w[g]),
                .acc_in(acc_q[(g + 1) % NEURONS]),
                .prev_in((g == NEURONS - 1) ? prev_fb : prev_q[(g + 1) % NEURONS]),
                .acc_out(acc_q[g]),
                .prev_out(prev_q[g])
            );
        end
    endgenerate

    // In ACC, cell NEURONS-1 sees cell 0's old value after shifting: accumulate there.
    always_comb
    begin
        cell_ctrl = '0;
        st_next = st_reg;
        cnt_next = cnt_reg;
        issued_next = issued_reg;
        done_next = done_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_acc && in_item.mode == MODE_FEAT)
                begin
                    st_next = ST_ACC;
                    cnt_next = '0;
                end
            end
            ST_ACC:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg != '0)
                begin
                    cell_ctrl.shift = 1'b1;
                    cell_ctrl.acc_en = feat_ok_reg;
                end
                if (cnt_reg == 7'(NEURONS))
                begin
                    cnt_next = '0;
                    st_next = last_reg ? ST_EVAL : ST_IDLE;
                    issued_next = '0;
                    done_next = '0;
                end
            end
            ST_EVAL:
            begin
                if (step)
                begin
                    issued_next = issued_reg + 7'd1;
                end
                if (vpipe_reg[LAT])
                begin
                    done_next = done_reg + 7'd1;
                    cell_ctrl.shift = 1'b1;
                end
                if (done_reg == 7'(NEURONS))
                begin
                    st_next = ST_ROT;
                    cnt_next = '0;
                end
            end
            ST_ROT:
            begin
                cell_ctrl.clear = 1'b1;
                cell_ctrl.shift = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(NEURONS - SH - 1))
                begin
                    cnt_next = '0;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            cnt_reg <= '0;
            issued_reg <= '0;
            done_reg <= '0;
            vpipe_reg <= '0;
            out_v_reg <= 1'b0;
            feat_ok_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            issued_reg <= issued_next;
            done_reg <= done_next;
            vpipe_reg <= {vpipe_reg[LAT-1:0], step};
            if (in_acc && in_item.mode == MODE_FEAT)
            begin
                feat_ok_reg <= load_f_ok;
                last_reg <= in_item.last;
            end
            if (vpipe_reg[LAT])
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && in_item.mode == MODE_FEAT)
        begin
            feat_reg <= in_item.value;
            fidx_reg <= in_item.feature_index;
        end
        acc_sel_reg <= acc_q[0];
        prev_sel_reg <= prev_q[0];
        npipe_reg[0] <= rd_n;
        for (int i = 1; i <= LAT; i++)
        begin
            npipe_reg[i] <= npipe_reg[i-1];
        end
        if (vpipe_reg[LAT])
        begin
            out_reg.neuron_number <= 6'(npipe_reg[LAT]);
            out_reg.state_value <= state_eval;
            out_reg.final_res <= (npipe_reg[LAT] == NW'(NEURONS - 1));
        end
    end

    rru_neuron_eval u_eval (
        .clk(clk),
        .acc(acc_sel_reg),
        .bias(bias_rd_reg),
        .prev(prev_sel_reg),
        .input_gain(input_gain_reg),
        .feedback_gain(feedback_gain_reg),
        .slope(slope_reg),
        .offset(offset_reg),
        .state(state_eval)
    );

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (st_reg == ST_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ch.ready) |=> $stable(out_reg)) else $error("output changed");
    a_done_le: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg <= issued_reg) else $error("done beyond issued");
endmodule
